[hdl/ping_pong_adc_capture_sequencer_unit_macros.svh]
// assertion macros for the ping-pong adc capture sequencer
`ifndef PING_PONG_ADC_CAPTURE_SEQUENCER_UNIT_MACROS_SVH
`define PING_PONG_ADC_CAPTURE_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define PPADC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define PPADC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/ppadc_pkg.sv]
// types and constants shared by the adc capture sequencer files
`default_nettype none
package ppadc_pkg;

	localparam int unsigned BANK_BYTES_DEF = 512;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned WIDX_W   = 9;
	localparam int unsigned SLEN_W   = 10;

	localparam logic [SAMPLE_W-1:0] HI_BYTE_MASK = 16'hFF00;
	localparam logic [SAMPLE_W-1:0] LO_BYTE_MASK = 16'h00FF;

	typedef enum logic [2:0] {
		PH_INIT   = 3'd0,
		PH_START  = 3'd1,
		PH_FILL_A = 3'd2,
		PH_FILL_B = 3'd3,
		PH_SEND_A = 3'd4,
		PH_SEND_B = 3'd5,
		PH_WAIT   = 3'd6,
		PH_FATAL  = 3'd7
	} phase_t;

	typedef struct packed {
		logic                run_enable;
		logic                init_ok;
		logic                adc_busy;
		logic                sample_valid;
		logic [SAMPLE_W-1:0] sample;
		logic                dma_done;
	} item_t;

	typedef struct packed {
		phase_t              phase;
		logic                convert_strobe;
		logic                write_enable;
		logic                write_bank;
		logic [WIDX_W-1:0]   write_index;
		logic [SAMPLE_W-1:0] write_word;
		logic                send_request;
		logic                send_bank;
		logic [SLEN_W-1:0]   send_length;
		logic                fatal;
	} result_t;

endpackage
`default_nettype wire

[hdl/ppadc_item_if.sv]
// input channel of the adc capture sequencer
`default_nettype none
interface ppadc_item_if;
	import ppadc_pkg::*;

	logic                valid;
	logic                ready;
	logic                run_enable;
	logic                init_ok;
	logic                adc_busy;
	logic                sample_valid;
	logic [SAMPLE_W-1:0] sample;
	logic                dma_done;

	modport source (
		output valid, run_enable, init_ok, adc_busy, sample_valid, sample, dma_done,
		input  ready
	);
	modport sink (
		input  valid, run_enable, init_ok, adc_busy, sample_valid, sample, dma_done,
		output ready
	);
endinterface
`default_nettype wire

[hdl/ppadc_result_if.sv]
// result channel of the adc capture sequencer
`default_nettype none
interface ppadc_result_if;
	import ppadc_pkg::*;

	logic                valid;
	logic                ready;
	logic [2:0]          phase;
	logic                convert_strobe;
	logic                write_enable;
	logic                write_bank;
	logic [WIDX_W-1:0]   write_index;
	logic [SAMPLE_W-1:0] write_word;
	logic                send_request;
	logic                send_bank;
	logic [SLEN_W-1:0]   send_length;
	logic                fatal;

	modport source (
		output valid, phase, convert_strobe, write_enable, write_bank, write_index,
		       write_word, send_request, send_bank, send_length, fatal,
		input  ready
	);
	modport sink (
		input  valid, phase, convert_strobe, write_enable, write_bank, write_index,
		       write_word, send_request, send_bank, send_length, fatal,
		output ready
	);
endinterface
`default_nettype wire

[hdl/ping_pong_adc_capture_sequencer_unit.sv]
// top level of the ping-pong adc capture sequencer
//
// item channel: one beat per sequencer tick, carrying run enable, init result,
// converter busy, sample valid, the 16-bit sample and the transfer-done flag
// result channel: one beat per item beat, in order, with the phase after the
// tick, the convert strobe, the bank write (bank, byte index, word) and the
// send request (bank, byte length) plus the sticky fatal flag
// path: an item taken sits in the input stage, the transition logic runs
// against the sequencer state and the result register loads from it, and
// the result beat is offered from the result register
// throughput: one item per cycle sustained while the result channel does not
// stall; the only loop is the state register fed by one compare and one small add of the fill index
// a stalled result channel holds the result register; the input stage still
// takes one more beat, then item ready drops until the result is taken
// reset: phase init, bank a, both fill indices zero, first-send flag clear,
// both stages empty; fatal stays latched until the next reset
`default_nettype none
`include "ping_pong_adc_capture_sequencer_unit_macros.svh"
module ping_pong_adc_capture_sequencer_unit #(
	parameter int unsigned BANK_BYTES = ppadc_pkg::BANK_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	ppadc_item_if.sink      item,
	ppadc_result_if.source  result
);
	import ppadc_pkg::*;

	// input stage
	logic    valid_s1;
	item_t   item_s1;
	// result stage
	logic    valid_s2;
	result_t res_s2;
	// next result from the transition logic
	result_t res_c;
	logic    advance;

	// move the input stage on when the result register is free or drains now
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.run_enable   <= item.run_enable;
			item_s1.init_ok      <= item.init_ok;
			item_s1.adc_busy     <= item.adc_busy;
			item_s1.sample_valid <= item.sample_valid;
			item_s1.sample       <= item.sample;
			item_s1.dma_done     <= item.dma_done;
		end
	end

	// state registers and transition, updated once per tick that moves on
	ppadc_step #(
		.BANK_BYTES(BANK_BYTES)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.res    (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_c;
		end
	end

	assign result.valid          = valid_s2;
	assign result.phase          = res_s2.phase;
	assign result.convert_strobe = res_s2.convert_strobe;
	assign result.write_enable   = res_s2.write_enable;
	assign result.write_bank     = res_s2.write_bank;
	assign result.write_index    = res_s2.write_index;
	assign result.write_word     = res_s2.write_word;
	assign result.send_request   = res_s2.send_request;
	assign result.send_bank      = res_s2.send_bank;
	assign result.send_length    = res_s2.send_length;
	assign result.fatal          = res_s2.fatal;

	// checks
	`PPADC_ASSERT_NEXT(a_fatal_sticky, valid_s2 && res_s2.fatal, !valid_s2 || res_s2.fatal, "fatal phase left without reset")
	`PPADC_ASSERT_NOW(a_stall_only_on_full, !item.ready, valid_s1 && valid_s2 && !result.ready, "input stalled while a stage is free")
	`PPADC_ASSERT_NOW(a_write_then_start, valid_s2 && (res_s2.write_enable || res_s2.send_request), res_s2.phase == PH_START, "bank write or send not followed by start phase")
	`PPADC_ASSERT_NOW(a_strobe_phase, valid_s2 && res_s2.convert_strobe, res_s2.phase == PH_START || res_s2.phase == PH_WAIT, "convert strobe outside conversion")
endmodule
`default_nettype wire

[hdl/ppadc_step.sv]
// sequencer state and the per-tick transition logic
`default_nettype none
module ppadc_step #(
	parameter int unsigned BANK_BYTES = ppadc_pkg::BANK_BYTES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire ppadc_pkg::item_t  item,
	output ppadc_pkg::result_t     res
);
	import ppadc_pkg::*;

	localparam int unsigned IDX_W = $clog2(BANK_BYTES + 1);
	localparam logic [IDX_W-1:0] FULL_MARK = IDX_W'(BANK_BYTES - 1);
	localparam logic [IDX_W-1:0] IDX_STEP  = IDX_W'(2);

	phase_t           phase_q, phase_nxt;
	logic             bank_q, bank_nxt;
	logic [IDX_W-1:0] fill_a_q, fill_a_nxt;
	logic [IDX_W-1:0] fill_b_q, fill_b_nxt;
	logic             first_q, first_nxt;
	logic             cur_b;
	logic [IDX_W-1:0] cur_idx;

	assign cur_b   = (phase_q == PH_FILL_B);
	assign cur_idx = cur_b ? fill_b_q : fill_a_q;

	always_comb begin
		phase_nxt  = phase_q;
		bank_nxt   = bank_q;
		fill_a_nxt = fill_a_q;
		fill_b_nxt = fill_b_q;
		first_nxt  = first_q;
		res        = '0;
		if (item.run_enable) begin
			unique case (phase_q)
				PH_INIT: begin
					if (item.init_ok) begin
						first_nxt = 1'b1;
						phase_nxt = PH_START;
					end else begin
						phase_nxt = PH_FATAL;
					end
				end
				PH_START: begin
					res.convert_strobe = 1'b1;
					if (item.adc_busy) begin
						phase_nxt = PH_WAIT;
					end
				end
				PH_WAIT: begin
					if (!item.adc_busy) begin
						phase_nxt = bank_q ? PH_FILL_B : PH_FILL_A;
					end
				end
				PH_FILL_A, PH_FILL_B: begin
					if (cur_idx < FULL_MARK) begin
						if (item.sample_valid) begin
							res.write_enable = 1'b1;
							res.write_bank   = cur_b;
							res.write_index  = WIDX_W'(cur_idx);
							res.write_word   = (item.sample & HI_BYTE_MASK)
							                 | (item.sample & LO_BYTE_MASK);
							if (cur_b) begin
								fill_b_nxt = cur_idx + IDX_STEP;
							end else begin
								fill_a_nxt = cur_idx + IDX_STEP;
							end
							phase_nxt = PH_START;
						end else begin
							phase_nxt = PH_FATAL;
						end
					end else begin
						phase_nxt = cur_b ? PH_SEND_B : PH_SEND_A;
					end
				end
				PH_SEND_A: begin
					if (item.dma_done || first_q) begin
						first_nxt         = 1'b0;
						res.send_request  = 1'b1;
						res.send_bank     = 1'b0;
						res.send_length   = SLEN_W'(fill_a_q);
						fill_a_nxt        = '0;
						bank_nxt          = 1'b1;
						phase_nxt         = PH_START;
					end else begin
						phase_nxt = PH_FATAL;
					end
				end
				PH_SEND_B: begin
					if (item.dma_done) begin
						res.send_request  = 1'b1;
						res.send_bank     = 1'b1;
						res.send_length   = SLEN_W'(fill_b_q);
						fill_b_nxt        = '0;
						bank_nxt          = 1'b0;
						phase_nxt         = PH_START;
					end else begin
						phase_nxt = PH_FATAL;
					end
				end
				PH_FATAL: begin
					phase_nxt = PH_FATAL;
				end
			endcase
		end
		res.phase = phase_nxt;
		res.fatal = (phase_nxt == PH_FATAL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_INIT;
			bank_q   <= 1'b0;
			fill_a_q <= '0;
			fill_b_q <= '0;
			first_q  <= 1'b0;
		end else if (fire) begin
			phase_q  <= phase_nxt;
			bank_q   <= bank_nxt;
			fill_a_q <= fill_a_nxt;
			fill_b_q <= fill_b_nxt;
			first_q  <= first_nxt;
		end
	end
endmodule
`default_nettype wire
